// ===== rtl/rhls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhls_pkg
// shared types and widths for the rgb to hls pixel converter
// ----------------------------------------------------------------------------
package rhls_pkg;

    localparam int PIX_W   = 8;             // channel and result width
    localparam int SAT_N_W = 16;            // 255 * range
    localparam int SAT_D_W = 8;             // saturation divisor
    localparam int HUE_NUM_W = 11;          // hue numerator, up to 6 * range
    localparam int HUE_N_W = 19;            // 255 * hue numerator
    localparam int HUE_D_W = 11;            // 6 * range
    localparam int DIV_STAGES = 4;          // two quotient bits per stage
    localparam int FRONT_STAGES = 3;

    // channel holding the maximum, ties resolved blue, green, red
    typedef enum logic [1:0] {
        SEL_RED,
        SEL_GREEN,
        SEL_BLUE
    } t_max_sel;

    // after max/min search
    typedef struct packed {
        logic [PIX_W-1:0]  hi;
        logic [PIX_W-1:0]  lo;
        t_max_sel          sel;
        logic signed [PIX_W:0] diff;
    } t_stage_a;

    // after range, sum and hue numerator
    typedef struct packed {
        logic [PIX_W-1:0]     range;
        logic [PIX_W-1:0]     light;
        logic [SAT_D_W-1:0]   den;
        logic [HUE_NUM_W-1:0] num;
    } t_stage_b;

    // divider state, shared by the setup stage and every divide stage
    typedef struct packed {
        logic [SAT_N_W-1:0] sat_rem;
        logic [SAT_D_W-1:0] sat_d;
        logic [PIX_W-1:0]   sat_q;
        logic [HUE_N_W-1:0] hue_rem;
        logic [HUE_D_W-1:0] hue_d;
        logic [PIX_W-1:0]   hue_q;
        logic [PIX_W-1:0]   light;
        logic               grey;
    } t_div;

endpackage

// ===== rtl/rhls_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhls_front
// max/min search, hue numerator and divider operand setup (three stages)
// ----------------------------------------------------------------------------
module rhls_front (
    input  logic                        i_clk,
    input  logic [rhls_pkg::FRONT_STAGES-1:0] i_en,
    input  logic [rhls_pkg::PIX_W-1:0]  i_red,
    input  logic [rhls_pkg::PIX_W-1:0]  i_green,
    input  logic [rhls_pkg::PIX_W-1:0]  i_blue,
    output rhls_pkg::t_div              o_div
);

    rhls_pkg::t_stage_a r_a, n_a;
    rhls_pkg::t_stage_b r_b, n_b;
    rhls_pkg::t_div     r_c, n_c;

    // stage a: max, min and signed channel difference
    always_comb begin
        n_a = '0;
        if (i_blue >= i_red && i_blue >= i_green) begin
            n_a.sel  = rhls_pkg::SEL_BLUE;
            n_a.hi   = i_blue;
            n_a.diff = $signed({1'b0, i_red}) - $signed({1'b0, i_green});
        end else if (i_green >= i_red) begin
            n_a.sel  = rhls_pkg::SEL_GREEN;
            n_a.hi   = i_green;
            n_a.diff = $signed({1'b0, i_blue}) - $signed({1'b0, i_red});
        end else begin
            n_a.sel  = rhls_pkg::SEL_RED;
            n_a.hi   = i_red;
            n_a.diff = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
        end
        n_a.lo = i_red;
        if (i_green < n_a.lo) begin
            n_a.lo = i_green;
        end
        if (i_blue < n_a.lo) begin
            n_a.lo = i_blue;
        end
    end

    // stage b: range, lightness, saturation divisor, wrapped hue numerator
    logic [rhls_pkg::PIX_W:0]         b_sum;
    logic [rhls_pkg::PIX_W+1:0]       b_rsum;
    logic [rhls_pkg::HUE_D_W-1:0]     b_six_r;
    logic signed [rhls_pkg::HUE_NUM_W:0] b_kr;
    logic signed [rhls_pkg::HUE_NUM_W:0] b_num;

    always_comb begin
        n_b       = '0;
        n_b.range = r_a.hi - r_a.lo;
        b_sum     = {1'b0, r_a.hi} + {1'b0, r_a.lo};
        b_rsum    = 10'd510 - {1'b0, b_sum};
        n_b.light = b_sum[rhls_pkg::PIX_W:1];
        n_b.den   = b_sum[rhls_pkg::PIX_W] ? b_rsum[rhls_pkg::PIX_W-1:0]
                                           : b_sum[rhls_pkg::PIX_W-1:0];
        b_six_r   = {1'b0, n_b.range, 2'b00} + {2'b00, n_b.range, 1'b0};
        unique case (r_a.sel)
            rhls_pkg::SEL_BLUE:  b_kr = $signed({2'b00, n_b.range, 2'b00});
            rhls_pkg::SEL_GREEN: b_kr = $signed({3'b000, n_b.range, 1'b0});
            default:             b_kr = $signed({1'b0, b_six_r});
        endcase
        b_num = b_kr + {{(rhls_pkg::HUE_NUM_W - rhls_pkg::PIX_W){r_a.diff[rhls_pkg::PIX_W]}},
                        r_a.diff};
        // above 360 degrees wraps once, exactly 360 stays
        if (b_num > $signed({1'b0, b_six_r})) begin
            b_num = b_num - $signed({1'b0, b_six_r});
        end
        n_b.num = b_num[rhls_pkg::HUE_NUM_W-1:0];
    end

    // stage c: scale numerators by 255 and set up both dividers
    always_comb begin
        n_c         = '0;
        n_c.sat_rem = {r_b.range, 8'h00} - {8'h00, r_b.range};
        n_c.sat_d   = r_b.den;
        n_c.hue_rem = {r_b.num, 8'h00} - {8'h00, r_b.num};
        n_c.hue_d   = {1'b0, r_b.range, 2'b00} + {2'b00, r_b.range, 1'b0};
        n_c.light   = r_b.light;
        n_c.grey    = (r_b.range == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_a <= n_a;
        end
        if (i_en[1]) begin
            r_b <= n_b;
        end
        if (i_en[2]) begin
            r_c <= n_c;
        end
    end

    assign o_div = r_c;

endmodule

// ===== rtl/rhls_div_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhls_div_stage
// two restoring division steps for saturation and hue, registered
// ----------------------------------------------------------------------------
module rhls_div_stage #(
    parameter int SHIFT = 7   // weight of the upper quotient bit of this stage
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  rhls_pkg::t_div i_div,
    output rhls_pkg::t_div o_div
);

    rhls_pkg::t_div r_div, n_div;
    logic [rhls_pkg::SAT_N_W-1:0] sat_dsh;
    logic [rhls_pkg::HUE_N_W-1:0] hue_dsh;

    always_comb begin
        n_div   = i_div;
        sat_dsh = '0;
        hue_dsh = '0;
        for (int j = 0; j < 2; j++) begin
            sat_dsh = {{(rhls_pkg::SAT_N_W - rhls_pkg::SAT_D_W){1'b0}}, n_div.sat_d}
                      << (SHIFT - j);
            hue_dsh = {{(rhls_pkg::HUE_N_W - rhls_pkg::HUE_D_W){1'b0}}, n_div.hue_d}
                      << (SHIFT - j);
            if (n_div.sat_rem >= sat_dsh) begin
                n_div.sat_rem = n_div.sat_rem - sat_dsh;
                n_div.sat_q   = {n_div.sat_q[rhls_pkg::PIX_W-2:0], 1'b1};
            end else begin
                n_div.sat_q   = {n_div.sat_q[rhls_pkg::PIX_W-2:0], 1'b0};
            end
            if (n_div.hue_rem >= hue_dsh) begin
                n_div.hue_rem = n_div.hue_rem - hue_dsh;
                n_div.hue_q   = {n_div.hue_q[rhls_pkg::PIX_W-2:0], 1'b1};
            end else begin
                n_div.hue_q   = {n_div.hue_q[rhls_pkg::PIX_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;

endmodule

// ===== rtl/rgb_to_hls_pixel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hls_pixel
// 8-bit rgb pixel to 8-bit hue, lightness and saturation, fully pipelined
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake           payload
//  -------   ---------  ------------------  ---------------------------------
//  pixel in  input      i_valid / o_stall   i_red_in, i_green_in, i_blue_in
//  hls out   output     o_valid / i_stall   o_hue_out, o_lightness_out,
//                                           o_saturation_out
//
//  one pixel per clock while the output is not stalled; the pipeline has
//  3 front stages, 4 divide stages of two quotient bits each, output reg;
//  each stage holds one pixel
//  i_rst_n is synchronous and clears only the per-stage valid bits
//  stalls back up stage by stage; empty stages still fill while the output
//  is stalled, so o_stall rises only when every stage holds a pixel
//
module rgb_to_hls_pixel (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_red_in,
    input  logic [7:0] i_green_in,
    input  logic [7:0] i_blue_in,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_hue_out,
    output logic [7:0] o_lightness_out,
    output logic [7:0] o_saturation_out
);

    localparam int NSTG = rhls_pkg::FRONT_STAGES + rhls_pkg::DIV_STAGES + 1;
    localparam int OUT  = NSTG - 1;

    // per-stage valid bits and load enables
    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] n_v;
    logic [NSTG-1:0] stg_en;

    // a stage loads when it is empty or its content moves on this cycle
    always_comb begin
        stg_en[OUT] = !r_v[OUT] || !i_stall;
        for (int k = OUT - 1; k >= 0; k--) begin
            stg_en[k] = !r_v[k] || stg_en[k+1];
        end
    end

    always_comb begin
        n_v = r_v;
        if (stg_en[0]) begin
            n_v[0] = i_valid;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (stg_en[k]) begin
                n_v[k] = r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_stall = !stg_en[0];

    // front end: max/min, hue numerator, divider setup
    rhls_pkg::t_div div_chain [rhls_pkg::DIV_STAGES+1];

    rhls_front u_front (
        .i_clk   (i_clk),
        .i_en    (stg_en[rhls_pkg::FRONT_STAGES-1:0]),
        .i_red   (i_red_in),
        .i_green (i_green_in),
        .i_blue  (i_blue_in),
        .o_div   (div_chain[0])
    );

    // divide pipeline, quotient bits 7..0 two per stage
    for (genvar s = 0; s < rhls_pkg::DIV_STAGES; s++) begin : g_div
        rhls_div_stage #(
            .SHIFT (2 * (rhls_pkg::DIV_STAGES - s) - 1)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (stg_en[rhls_pkg::FRONT_STAGES + s]),
            .i_div (div_chain[s]),
            .o_div (div_chain[s+1])
        );
    end

    // output register; grey pixels force hue and saturation to zero
    rhls_pkg::t_div div_last;
    logic [7:0] r_hue;
    logic [7:0] r_light;
    logic [7:0] r_sat;

    assign div_last = div_chain[rhls_pkg::DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (stg_en[OUT]) begin
            r_hue   <= div_last.grey ? '0 : div_last.hue_q;
            r_light <= div_last.light;
            r_sat   <= div_last.grey ? '0 : div_last.sat_q;
        end
    end

    assign o_valid          = r_v[OUT];
    assign o_hue_out        = r_hue;
    assign o_lightness_out  = r_light;
    assign o_saturation_out = r_sat;

`ifndef ASSERT_OFF
    // an empty output register never lets a stall reach the input side
    a_no_stall_when_out_empty: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall
    ) else $error("input stalled while output register empty");

    // zero saturation only for grey pixels, which also have zero hue
    a_grey_hue_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturation_out == 8'd0) |-> (o_hue_out == 8'd0)
    ) else $error("zero saturation with nonzero hue");

    // reset empties the whole pipeline
    a_reset_clears: assert property (
        @(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall)
    ) else $error("pipeline not empty after reset");
`endif

endmodule

// ===== tb/tb_rgb_to_hls_pixel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_to_hls_pixel
// self-checking bench for the rgb to hue/lightness/saturation pixel converter
// ----------------------------------------------------------------------------
//
//  pixels go from a pending queue onto the input channel through a clocked
//  driver; every accepted transfer is run through an integer model of the
//  conversion and the expected hls triple is queued. a clocked monitor takes
//  every output transfer and compares it field by field with the oldest
//  expected triple.
//
//  stimulus: a directed set of corner pixels (greys, primaries, tied maxima,
//  hue wrap and the exact 360 degree case, saturation divisor switch), then
//  random pixels in three phases with different idle and stall mixes. the
//  sender drains the block completely between phases.
//
module tb_rgb_to_hls_pixel;

    localparam int CLK_HALF   = 5;
    localparam int N_RANDOM   = 2000;
    localparam int DRAIN_CYC  = 24;     // margin above the block latency

    typedef struct {
        logic [rhls_pkg::PIX_W-1:0] red;
        logic [rhls_pkg::PIX_W-1:0] green;
        logic [rhls_pkg::PIX_W-1:0] blue;
    } t_pixel;

    typedef struct {
        logic [rhls_pkg::PIX_W-1:0] hue;
        logic [rhls_pkg::PIX_W-1:0] light;
        logic [rhls_pkg::PIX_W-1:0] sat;
    } t_hls;

    // clock and reset
    logic                       i_clk   = 1'b0;
    logic                       i_rst_n = 1'b0;

    // pixel input channel
    logic                       i_valid    = 1'b0;
    logic                       o_stall;
    logic [rhls_pkg::PIX_W-1:0] i_red_in   = '0;
    logic [rhls_pkg::PIX_W-1:0] i_green_in = '0;
    logic [rhls_pkg::PIX_W-1:0] i_blue_in  = '0;

    // hls output channel
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic [rhls_pkg::PIX_W-1:0] o_hue_out;
    logic [rhls_pkg::PIX_W-1:0] o_lightness_out;
    logic [rhls_pkg::PIX_W-1:0] o_saturation_out;

    // stimulus and scoreboard state
    t_pixel pending_pixels[$];
    t_hls   expected_hls[$];
    t_pixel next_pixel;
    t_hls   oldest_hls;
    int     send_idle_pct  = 0;     // chance in 100 that the sender idles
    int     recv_stall_pct = 0;     // chance in 100 that the receiver stalls
    int     mismatches     = 0;

    always #CLK_HALF i_clk = ~i_clk;

    rgb_to_hls_pixel i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_red_in         (i_red_in),
        .i_green_in       (i_green_in),
        .i_blue_in        (i_blue_in),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_hue_out        (o_hue_out),
        .o_lightness_out  (o_lightness_out),
        .o_saturation_out (o_saturation_out)
    );

    // ------------------------------------------------------------------------
    // integer model of the conversion, exact rationals with floor
    // ------------------------------------------------------------------------
    function automatic t_hls predict_hls(input t_pixel px);
        int                 r;
        int                 g;
        int                 b;
        int                 hi;
        int                 lo;
        int                 span;
        int                 sum;
        int                 den;
        int                 num;
        rhls_pkg::t_max_sel sel;
        t_hls               res;
        r    = px.red;
        g    = px.green;
        b    = px.blue;
        hi   = (r > g) ? r : g;
        hi   = (hi > b) ? hi : b;
        lo   = (r < g) ? r : g;
        lo   = (lo < b) ? lo : b;
        span = hi - lo;
        sum  = hi + lo;
        res.light = rhls_pkg::PIX_W'(sum / 2);
        res.hue   = '0;
        res.sat   = '0;
        if (span != 0) begin
            // saturation divisor flips past the midpoint of the sum
            den     = (sum <= 255) ? sum : (510 - sum);
            res.sat = rhls_pkg::PIX_W'((255 * span) / den);
            // tied maxima: blue wins over green, green over red
            if (b == hi)
                sel = rhls_pkg::SEL_BLUE;
            else if (g == hi)
                sel = rhls_pkg::SEL_GREEN;
            else
                sel = rhls_pkg::SEL_RED;
            case (sel)
                rhls_pkg::SEL_BLUE:  num = 4 * span + (r - g);
                rhls_pkg::SEL_GREEN: num = 2 * span + (b - r);
                default:             num = 6 * span + (g - b);
            endcase
            // wrap past 360 degrees, exactly 360 stays
            if (num > 6 * span)
                num -= 6 * span;
            res.hue = rhls_pkg::PIX_W'((num * 255) / (6 * span));
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic queue_pixel(input int r, input int g, input int b);
        t_pixel px;
        px.red   = rhls_pkg::PIX_W'(r);
        px.green = rhls_pkg::PIX_W'(g);
        px.blue  = rhls_pkg::PIX_W'(b);
        pending_pixels.push_back(px);
    endtask

    // mostly uniform pixels, with greys, two-channel ties and near-rail values
    function automatic t_pixel random_pixel();
        t_pixel px;
        int     mode;
        int     v;
        mode     = $urandom_range(0, 9);
        px.red   = rhls_pkg::PIX_W'($urandom);
        px.green = rhls_pkg::PIX_W'($urandom);
        px.blue  = rhls_pkg::PIX_W'($urandom);
        case (mode)
            0: begin
                px.green = px.red;
                px.blue  = px.red;
            end
            1: begin
                v = $urandom_range(0, 2);
                if (v == 0)
                    px.green = px.red;
                else if (v == 1)
                    px.blue = px.green;
                else
                    px.blue = px.red;
            end
            2: begin
                px.red   = $urandom_range(0, 1) ? rhls_pkg::PIX_W'($urandom_range(250, 255))
                                                : rhls_pkg::PIX_W'($urandom_range(0, 5));
                px.green = $urandom_range(0, 1) ? rhls_pkg::PIX_W'($urandom_range(250, 255))
                                                : rhls_pkg::PIX_W'($urandom_range(0, 5));
                px.blue  = $urandom_range(0, 1) ? rhls_pkg::PIX_W'($urandom_range(250, 255))
                                                : rhls_pkg::PIX_W'($urandom_range(0, 5));
            end
            default: ;
        endcase
        return px;
    endfunction

    // wait until every queued pixel has been transferred and answered
    task automatic wait_drained();
        while (pending_pixels.size() != 0 || i_valid || expected_hls.size() != 0)
            @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // driver: offers the next pending pixel, holds it while stalled
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            // transfer on the input side, queue its expected result
            if (i_valid && !o_stall) begin
                next_pixel.red   = i_red_in;
                next_pixel.green = i_green_in;
                next_pixel.blue  = i_blue_in;
                expected_hls.push_back(predict_hls(next_pixel));
            end
            // payload may change only when nothing is held by a stall
            if (!i_valid || !o_stall) begin
                if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_pixel = pending_pixels.pop_front();
                    i_valid    <= 1'b1;
                    i_red_in   <= next_pixel.red;
                    i_green_in <= next_pixel.green;
                    i_blue_in  <= next_pixel.blue;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // monitor: every output transfer against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_hls.size() == 0) begin
                report_mismatch($sformatf("result with none expected: h=%0d l=%0d s=%0d",
                                          o_hue_out, o_lightness_out, o_saturation_out));
            end else begin
                oldest_hls = expected_hls.pop_front();
                if (o_hue_out !== oldest_hls.hue)
                    report_mismatch($sformatf("hue got %0d expected %0d",
                                              o_hue_out, oldest_hls.hue));
                if (o_lightness_out !== oldest_hls.light)
                    report_mismatch($sformatf("lightness got %0d expected %0d",
                                              o_lightness_out, oldest_hls.light));
                if (o_saturation_out !== oldest_hls.sat)
                    report_mismatch($sformatf("saturation got %0d expected %0d",
                                              o_saturation_out, oldest_hls.sat));
            end
        end
    end

    // ------------------------------------------------------------------------
    // sequence: reset, directed corners, three random phases, drain
    // ------------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // greys, including both rails
        queue_pixel(0, 0, 0);
        queue_pixel(255, 255, 255);
        queue_pixel(128, 128, 128);
        // primaries; pure red sits at exactly 360 degrees
        queue_pixel(255, 0, 0);
        queue_pixel(0, 255, 0);
        queue_pixel(0, 0, 255);
        // red max, hue below and above 360 degrees
        queue_pixel(255, 0, 10);
        queue_pixel(255, 10, 0);
        // tied maxima
        queue_pixel(255, 255, 0);
        queue_pixel(0, 255, 255);
        queue_pixel(255, 0, 255);
        queue_pixel(100, 200, 200);
        // saturation divisor: sum right at and just past the switch
        queue_pixel(200, 55, 55);
        queue_pixel(200, 56, 56);
        // smallest spans at both ends of the sum
        queue_pixel(1, 0, 0);
        queue_pixel(255, 254, 254);
        queue_pixel(0, 1, 0);
        queue_pixel(254, 254, 255);
        // mixed values across all bits
        queue_pixel(170, 85, 51);
        queue_pixel(85, 170, 204);
        queue_pixel(15, 240, 127);
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 10;
                    recv_stall_pct = 82;
                end
                1: begin
                    send_idle_pct  = 82;
                    recv_stall_pct = 10;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int n = 0; n < N_RANDOM / 3; n++)
                pending_pixels.push_back(random_pixel());
            // sender stays quiet until every result of this phase is back
            wait_drained();
        end

        repeat (DRAIN_CYC) @(posedge i_clk);
        if (mismatches == 0 && expected_hls.size() == 0)
            $display("rgb_to_hls_pixel verification clean");
        else
            $display("rgb_to_hls_pixel verification failed");
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial begin
        #2_000_000;
        $display("rgb_to_hls_pixel verification failed");
        $finish;
    end

endmodule
